// ===== src/baar_pkg.sv =====
// ----------------------------------------------------------------------------
// Button action auto-repeat package
// Shared codes, widths and the job record passed from front to back.
// ----------------------------------------------------------------------------
package baar_pkg;

	localparam int TICK_BITS_DEF = 32;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int FIFO_DEPTH    = 2;
	localparam logic [15:0] WHEEL_DEFAULT_MS = 16'd50;
	localparam logic signed [14:0] NOTCH = 15'sd120;

	typedef enum logic [2:0] {
		KIND_NONE     = 3'd0,
		KIND_KEY      = 3'd1,
		KIND_MOUSE    = 3'd2,
		KIND_WHEEL    = 3'd3,
		KIND_WHEEL_UP = 3'd4,
		KIND_WHEEL_DN = 3'd5,
		KIND_PAD      = 3'd6,
		KIND_TRIG     = 3'd7
	} baar_kind_t;

	typedef enum logic [2:0] {
		REG_ACTION_KIND  = 3'd0,
		REG_ACTION_CODE  = 3'd1,
		REG_WHEEL_STEPS  = 3'd2,
		REG_KEY_REPEAT   = 3'd3,
		REG_MOUSE_REPEAT = 3'd4,
		REG_WHEEL_REPEAT = 3'd5
	} baar_reg_t;

	localparam logic [1:0] EVT_KEY   = 2'd0;
	localparam logic [1:0] EVT_MOUSE = 2'd1;
	localparam logic [1:0] EVT_WHEEL = 2'd2;

	typedef struct packed {
		logic              pair;
		logic              ev_valid;
		logic [1:0]        ev_type;
		logic [7:0]        ev_code;
		logic              ev_down;
		logic signed [14:0] wheel_amount;
		logic [15:0]       buttons;
		logic [7:0]        left_trigger;
		logic [7:0]        right_trigger;
	} baar_job_t;

endpackage

// ===== src/button_action_auto_repeat_core.sv =====
// A poll enters the job queue; its first result beat then loads into the output register.
// Throughput: while out_stall is low, one poll per cycle when it yields one beat, and the
// output register sends one beat per cycle; the two-entry job queue absorbs bursts.
// Reset (arst_n low): clears configuration, held flag, repeat tick, queue and output valid.
// ----------------------------------------------------------------------------
// Button action auto-repeat core
// Typematic key/mouse/wheel repeat and pad report merge for one control.
// ----------------------------------------------------------------------------
module button_action_auto_repeat_core import baar_pkg::*; #(
	parameter int TICK_BITS = TICK_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 pressed,
	input  logic [31:0]          now_ms,
	input  logic [7:0]           trigger_level,
	input  logic [15:0]          buttons_in,
	input  logic [7:0]           left_trigger_in,
	input  logic [7:0]           right_trigger_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 event_valid,
	output logic [1:0]           event_type,
	output logic [7:0]           event_code,
	output logic                 event_down,
	output logic signed [14:0]   wheel_amount,
	output logic [15:0]          buttons_out,
	output logic [7:0]           left_trigger_out,
	output logic [7:0]           right_trigger_out,
	output logic                 last
);

	logic      push;
	logic      pop;
	logic      full;
	logic      head_valid;
	baar_job_t wr_job;
	baar_job_t head;

	assign in_stall = full;

	baar_front #(.TICK_BITS(TICK_BITS)) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.full             (full),
		.pressed          (pressed),
		.now_ms           (now_ms),
		.trigger_level    (trigger_level),
		.buttons_in       (buttons_in),
		.left_trigger_in  (left_trigger_in),
		.right_trigger_in (right_trigger_in),
		.push             (push),
		.job              (wr_job)
	);

	baar_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_job     (wr_job),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	baar_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head_valid        (head_valid),
		.head              (head),
		.pop               (pop),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.event_valid       (event_valid),
		.event_type        (event_type),
		.event_code        (event_code),
		.event_down        (event_down),
		.wheel_amount      (wheel_amount),
		.buttons_out       (buttons_out),
		.left_trigger_out  (left_trigger_out),
		.right_trigger_out (right_trigger_out),
		.last              (last)
	);

endmodule

// ===== src/baar_front.sv =====
// ----------------------------------------------------------------------------
// Button action front end
// Holds configuration and held/repeat state, classifies each poll into a job.
// ----------------------------------------------------------------------------
module baar_front import baar_pkg::*; #(
	parameter int TICK_BITS = TICK_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 full,
	input  logic                 pressed,
	input  logic [31:0]          now_ms,
	input  logic [7:0]           trigger_level,
	input  logic [15:0]          buttons_in,
	input  logic [7:0]           left_trigger_in,
	input  logic [7:0]           right_trigger_in,
	output logic                 push,
	output baar_job_t            job
);

	baar_kind_t            kind_q;
	logic [15:0]           code_q;
	logic signed [7:0]     steps_q;
	logic [15:0]           key_rep_q;
	logic [15:0]           mouse_rep_q;
	logic [15:0]           wheel_rep_q;
	logic                  held_q;
	logic [TICK_BITS-1:0]  tick_q;

	logic                  held_d;
	logic [TICK_BITS-1:0]  tick_d;
	logic [TICK_BITS-1:0]  now_t;
	logic [TICK_BITS-1:0]  elapsed;
	logic                  is_key;
	logic [15:0]           rep_km;
	logic [15:0]           rep_wh;
	logic                  emit;
	logic [1:0]            km_type;
	logic signed [14:0]    steps_ext;
	logic signed [14:0]    wd;

	assign push    = in_valid && !full;
	assign now_t   = TICK_BITS'(now_ms);
	assign elapsed = now_t - tick_q;
	assign is_key  = (kind_q == KIND_KEY);
	assign rep_km  = is_key ? key_rep_q : mouse_rep_q;
	assign rep_wh  = (wheel_rep_q != 16'd0) ? wheel_rep_q : WHEEL_DEFAULT_MS;
	assign emit    = is_key || (code_q >= 16'd1 && code_q <= 16'd5);
	assign km_type = is_key ? EVT_KEY : EVT_MOUSE;
	assign steps_ext = 15'(steps_q);

	always_comb begin
		if (kind_q == KIND_WHEEL_DN)
			wd = -NOTCH;
		else if (steps_q != 8'sd0)
			wd = 15'(steps_ext * NOTCH);
		else
			wd = NOTCH;
	end

	always_comb begin
		job               = '0;
		job.buttons       = buttons_in;
		job.left_trigger  = left_trigger_in;
		job.right_trigger = right_trigger_in;
		held_d            = held_q;
		tick_d            = tick_q;
		unique case (kind_q)
			KIND_KEY, KIND_MOUSE: begin
				if (pressed && !held_q) begin
					job.ev_valid = emit;
					job.ev_down  = emit;
					held_d       = 1'b1;
					tick_d       = now_t;
				end else if (pressed) begin
					if (rep_km != 16'd0 && elapsed >= TICK_BITS'(rep_km)) begin
						job.pair     = emit;
						job.ev_valid = emit;
						tick_d       = now_t;
					end
				end else if (held_q) begin
					job.ev_valid = emit;
					held_d       = 1'b0;
				end
				if (job.ev_valid) begin
					job.ev_type = km_type;
					job.ev_code = code_q[7:0];
				end
			end
			KIND_WHEEL, KIND_WHEEL_UP, KIND_WHEEL_DN: begin
				if (pressed && !held_q) begin
					job.ev_valid = 1'b1;
					held_d       = 1'b1;
					tick_d       = now_t;
				end else if (pressed) begin
					if (elapsed >= TICK_BITS'(rep_wh)) begin
						job.ev_valid = 1'b1;
						tick_d       = now_t;
					end
				end else begin
					held_d = 1'b0;
				end
				if (job.ev_valid) begin
					job.ev_type      = EVT_WHEEL;
					job.wheel_amount = wd;
				end
			end
			KIND_PAD: begin
				if (pressed)
					job.buttons = buttons_in | code_q;
			end
			KIND_TRIG: begin
				if (pressed) begin
					if (code_q == 16'd0 && trigger_level > left_trigger_in)
						job.left_trigger = trigger_level;
					else if (code_q == 16'd1 && trigger_level > right_trigger_in)
						job.right_trigger = trigger_level;
				end
			end
			KIND_NONE: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= KIND_NONE;
			code_q      <= '0;
			steps_q     <= '0;
			key_rep_q   <= '0;
			mouse_rep_q <= '0;
			wheel_rep_q <= '0;
			held_q      <= 1'b0;
			tick_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ACTION_KIND:  kind_q      <= baar_kind_t'(cfg_data[2:0]);
					REG_ACTION_CODE:  code_q      <= cfg_data;
					REG_WHEEL_STEPS:  steps_q     <= cfg_data[7:0];
					REG_KEY_REPEAT:   key_rep_q   <= cfg_data;
					REG_MOUSE_REPEAT: mouse_rep_q <= cfg_data;
					REG_WHEEL_REPEAT: wheel_rep_q <= cfg_data;
					default: ;
				endcase
			end
			if (push) begin
				held_q <= held_d;
				tick_q <= tick_d;
			end
		end
	end

endmodule

// ===== src/baar_fifo.sv =====
// ----------------------------------------------------------------------------
// Job queue
// Short FIFO between the front end and the result sequencer.
// ----------------------------------------------------------------------------
module baar_fifo import baar_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  baar_job_t wr_job,
	input  logic      pop,
	output logic      full,
	output logic      head_valid,
	output baar_job_t head
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

	baar_job_t        mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty job queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full job queue");

endmodule

// ===== src/baar_back.sv =====
// ----------------------------------------------------------------------------
// Result sequencer
// Expands each job into one or two result beats through an output register.
// ----------------------------------------------------------------------------
module baar_back import baar_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  baar_job_t          head,
	output logic               pop,
	input  logic               out_stall,
	output logic               out_valid,
	output logic               event_valid,
	output logic [1:0]         event_type,
	output logic [7:0]         event_code,
	output logic               event_down,
	output logic signed [14:0] wheel_amount,
	output logic [15:0]        buttons_out,
	output logic [7:0]         left_trigger_out,
	output logic [7:0]         right_trigger_out,
	output logic               last
);

	logic out_valid_q;
	logic phase_q;
	logic last_q;
	logic load;

	assign load      = !out_valid_q || !out_stall;
	assign pop       = load && head_valid && (!head.pair || phase_q);
	assign out_valid = out_valid_q;
	assign last      = last_q;

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			event_valid       <= head.ev_valid;
			event_type        <= head.ev_type;
			event_code        <= head.ev_code;
			event_down        <= phase_q ? 1'b1 : head.ev_down;
			wheel_amount      <= head.wheel_amount;
			buttons_out       <= head.buttons;
			left_trigger_out  <= head.left_trigger;
			right_trigger_out <= head.right_trigger;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
			last_q      <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				last_q  <= !head.pair || phase_q;
				phase_q <= head.pair && !phase_q;
			end
		end
	end

	a_phase_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> head_valid) else $error("second beat pending without job");
	a_first_of_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> phase_q) else $error("lost second beat");
	a_phase_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(phase_q) |-> (out_valid_q && !last_q)) else $error("bad pair start");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Button action auto-repeat testbench
// Sends polls through the core under many action settings and keeps its own
// typematic model of the held flag and repeat tick. Every output beat is
// checked field by field against the oldest predicted event beat.
// ----------------------------------------------------------------------------
module testbench;
	import baar_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic        pressed;
		logic [31:0] now;
		logic [7:0]  level;
		logic [15:0] buttons;
		logic [7:0]  lt;
		logic [7:0]  rt;
	} poll_t;

	typedef struct packed {
		logic               ev_valid;
		logic [1:0]         ev_type;
		logic [7:0]         ev_code;
		logic               ev_down;
		logic signed [14:0] wheel;
		logic [15:0]        buttons;
		logic [7:0]         lt;
		logic [7:0]         rt;
		logic               last;
	} beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 pressed = 1'b0;
	logic [31:0]          now_ms = '0;
	logic [7:0]           trigger_level = '0;
	logic [15:0]          buttons_in = '0;
	logic [7:0]           left_trigger_in = '0;
	logic [7:0]           right_trigger_in = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 event_valid;
	logic [1:0]           event_type;
	logic [7:0]           event_code;
	logic                 event_down;
	logic signed [14:0]   wheel_amount;
	logic [15:0]          buttons_out;
	logic [7:0]           left_trigger_out;
	logic [7:0]           right_trigger_out;
	logic                 last;

	// action settings and typematic state as the core should hold them
	baar_kind_t         kind_r = KIND_NONE;
	logic [15:0]        code_r = '0;
	logic signed [7:0]  steps_r = '0;
	logic [15:0]        key_rep_r = '0;
	logic [15:0]        mouse_rep_r = '0;
	logic [15:0]        wheel_rep_r = '0;
	logic               held_r = 1'b0;
	logic [31:0]        tick_r = '0;

	poll_t poll_q[$];
	beat_t event_beats_q[$];
	poll_t drive_poll;
	beat_t want, got;
	logic  poll_taken = 1'b0;
	int    send_idle = 33;
	int    recv_idle = 84;
	int    polls_taken = 0;
	int    errs = 0;
	int    cycles = 0;
	int    hold_left = 0;
	logic  hold_fired = 1'b0;

	button_action_auto_repeat_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.pressed          (pressed),
		.now_ms           (now_ms),
		.trigger_level    (trigger_level),
		.buttons_in       (buttons_in),
		.left_trigger_in  (left_trigger_in),
		.right_trigger_in (right_trigger_in),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.event_valid      (event_valid),
		.event_type       (event_type),
		.event_code       (event_code),
		.event_down       (event_down),
		.wheel_amount     (wheel_amount),
		.buttons_out      (buttons_out),
		.left_trigger_out (left_trigger_out),
		.right_trigger_out(right_trigger_out),
		.last             (last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void typematic_step(input poll_t p);
		beat_t       ev [2];
		beat_t       rep;
		int          n;
		int          wsum;
		logic [31:0] elapsed;
		logic [15:0] interval;
		logic        emit;
		logic [15:0] b;
		logic [7:0]  lt;
		logic [7:0]  rt;
		b = p.buttons;
		lt = p.lt;
		rt = p.rt;
		n = 0;
		elapsed = p.now - tick_r;
		rep = '0;
		case (kind_r)
		KIND_KEY, KIND_MOUSE: begin
			interval = (kind_r == KIND_KEY) ? key_rep_r : mouse_rep_r;
			emit = (kind_r == KIND_KEY) || (code_r >= 16'd1 && code_r <= 16'd5);
			rep.ev_valid = 1'b1;
			rep.ev_type = (kind_r == KIND_KEY) ? EVT_KEY : EVT_MOUSE;
			rep.ev_code = code_r[7:0];
			if (p.pressed) begin
				if (!held_r) begin
					rep.ev_down = 1'b1;
					ev[0] = rep;
					if (emit) n = 1;
					held_r = 1'b1;
					tick_r = p.now;
				end else if (interval != 16'd0 && elapsed >= {16'd0, interval}) begin
					ev[0] = rep;
					rep.ev_down = 1'b1;
					ev[1] = rep;
					if (emit) n = 2;
					tick_r = p.now;
				end
			end else if (held_r) begin
				ev[0] = rep;
				if (emit) n = 1;
				held_r = 1'b0;
			end
		end
		KIND_WHEEL, KIND_WHEEL_UP, KIND_WHEEL_DN: begin
			interval = (wheel_rep_r != 16'd0) ? wheel_rep_r : WHEEL_DEFAULT_MS;
			rep.ev_valid = 1'b1;
			rep.ev_type = EVT_WHEEL;
			if (kind_r == KIND_WHEEL_DN) begin
				rep.wheel = -NOTCH;
			end else begin
				wsum = (steps_r != 8'sd0) ? int'(steps_r) * 120 : 120;
				rep.wheel = wsum[14:0];
			end
			if (p.pressed && (!held_r || elapsed >= {16'd0, interval})) begin
				ev[0] = rep;
				n = 1;
				held_r = 1'b1;
				tick_r = p.now;
			end else if (!p.pressed) begin
				held_r = 1'b0;
			end
		end
		KIND_PAD: begin
			if (p.pressed) b = b | code_r;
		end
		KIND_TRIG: begin
			if (p.pressed) begin
				if (code_r == 16'd0 && p.level > lt) lt = p.level;
				else if (code_r == 16'd1 && p.level > rt) rt = p.level;
			end
		end
		default: ;
		endcase
		if (n == 0) begin
			ev[0] = '0;
			n = 1;
		end
		for (int i = 0; i < n; i++) begin
			ev[i].buttons = b;
			ev[i].lt = lt;
			ev[i].rt = rt;
			ev[i].last = (i == n - 1);
			event_beats_q.push_back(ev[i]);
		end
	endfunction

	function automatic poll_t rand_poll(input logic p, input logic [31:0] t);
		poll_t r;
		r.pressed = p;
		r.now = t;
		r.level = 8'($urandom);
		r.buttons = 16'($urandom);
		r.lt = 8'($urandom);
		r.rt = 8'($urandom);
		if ($urandom_range(9) == 0) r.level = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
		return r;
	endfunction

	function automatic logic [15:0] pick_interval();
		case ($urandom_range(7))
		0: return 16'd0;
		1: return 16'hFFFF;
		2: return 16'd1;
		default: return 16'($urandom_range(2, 40));
		endcase
	endfunction

	task automatic settle();
		while (poll_q.size() != 0 || in_valid || event_beats_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_reg(input baar_reg_t r, input logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		case (r)
		REG_ACTION_KIND:  kind_r = baar_kind_t'(v[2:0]);
		REG_ACTION_CODE:  code_r = v;
		REG_WHEEL_STEPS:  steps_r = v[7:0];
		REG_KEY_REPEAT:   key_rep_r = v;
		REG_MOUSE_REPEAT: mouse_rep_r = v;
		REG_WHEEL_REPEAT: wheel_rep_r = v;
		default: ;
		endcase
	endtask

	task automatic configure(input baar_kind_t k, input logic [15:0] code,
			input logic [7:0] steps, input logic [15:0] kr, input logic [15:0] mr,
			input logic [15:0] wr);
		settle();
		set_reg(REG_ACTION_KIND, {13'd0, k});
		set_reg(REG_ACTION_CODE, code);
		set_reg(REG_WHEEL_STEPS, {8'd0, steps});
		set_reg(REG_KEY_REPEAT, kr);
		set_reg(REG_MOUSE_REPEAT, mr);
		set_reg(REG_WHEEL_REPEAT, wr);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// driver: advance to the next poll once the current beat is taken
	always @(negedge clk) begin
		if (!in_valid || poll_taken) begin
			if (poll_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				drive_poll = poll_q.pop_front();
				pressed <= drive_poll.pressed;
				now_ms <= drive_poll.now;
				trigger_level <= drive_poll.level;
				buttons_in <= drive_poll.buttons;
				left_trigger_in <= drive_poll.lt;
				right_trigger_in <= drive_poll.rt;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stall, plus one long hold while polls keep coming
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_fired && polls_taken >= 200 && poll_q.size() > 20) begin
			hold_fired <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {event_valid, event_type, event_code, event_down, wheel_amount,
					buttons_out, left_trigger_out, right_trigger_out, last};
				if (event_beats_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("unexpected beat: v%0b t%0d c%02h d%0b w%0d b%04h l%02h r%02h last%0b",
							got.ev_valid, got.ev_type, got.ev_code, got.ev_down, got.wheel,
							got.buttons, got.lt, got.rt, got.last);
				end else begin
					want = event_beats_q.pop_front();
					if (got !== want) begin
						errs++;
						if (errs <= 10)
							$display("beat mismatch: exp v%0b t%0d c%02h d%0b w%0d b%04h l%02h r%02h last%0b",
								want.ev_valid, want.ev_type, want.ev_code, want.ev_down, want.wheel,
								want.buttons, want.lt, want.rt, want.last,
								" / got v%0b t%0d c%02h d%0b w%0d b%04h l%02h r%02h last%0b",
								got.ev_valid, got.ev_type, got.ev_code, got.ev_down, got.wheel,
								got.buttons, got.lt, got.rt, got.last);
					end
				end
			end
			if (in_valid && !in_stall) begin
				typematic_step({pressed, now_ms, trigger_level, buttons_in,
					left_trigger_in, right_trigger_in});
				polls_taken++;
			end
		end
		poll_taken <= in_valid && !in_stall;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		poll_t       pp;
		baar_kind_t  k;
		logic [15:0] code;
		logic [7:0]  steps;
		logic [15:0] kr, mr, wr, cur_rep;
		logic [31:0] t, dt;
		logic        pr;
		int          n_rand;
		int          len;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed
		configure(KIND_NONE, 16'h0000, 8'h00, 16'd0, 16'd0, 16'd0);
		poll_q.push_back(poll_t'({1'b1, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF}));

		configure(KIND_KEY, 16'h01A5, 8'h00, 16'd10, 16'd0, 16'd0);
		poll_q.push_back(rand_poll(1'b1, 32'd100));
		poll_q.push_back(rand_poll(1'b1, 32'd105));
		poll_q.push_back(rand_poll(1'b1, 32'd110));
		poll_q.push_back(rand_poll(1'b0, 32'd111));

		configure(KIND_KEY, 16'h00FF, 8'h00, 16'd0, 16'd0, 16'd0);
		poll_q.push_back(rand_poll(1'b1, 32'd0));
		poll_q.push_back(rand_poll(1'b1, 32'd70000));
		poll_q.push_back(rand_poll(1'b0, 32'd70001));

		configure(KIND_MOUSE, 16'd3, 8'h00, 16'd0, 16'hFFFF, 16'd0);
		poll_q.push_back(rand_poll(1'b1, 32'hFFFF_FFF0));
		poll_q.push_back(rand_poll(1'b1, 32'h0000_FFEF));
		poll_q.push_back(rand_poll(1'b0, 32'h0001_0000));

		configure(KIND_MOUSE, 16'd9, 8'h00, 16'd0, 16'd1, 16'd0);
		poll_q.push_back(rand_poll(1'b1, 32'd10));
		poll_q.push_back(rand_poll(1'b1, 32'd11));
		poll_q.push_back(rand_poll(1'b0, 32'd12));

		configure(KIND_WHEEL, 16'd0, 8'h80, 16'd0, 16'd0, 16'd0);
		poll_q.push_back(rand_poll(1'b1, 32'd1000));
		poll_q.push_back(rand_poll(1'b1, 32'd1049));
		poll_q.push_back(rand_poll(1'b1, 32'd1050));
		poll_q.push_back(rand_poll(1'b0, 32'd1051));

		// switch kind while the control stays held
		configure(KIND_WHEEL_UP, 16'd0, 8'h7F, 16'd0, 16'd0, 16'd7);
		poll_q.push_back(rand_poll(1'b1, 32'd5));
		configure(KIND_WHEEL_DN, 16'd0, 8'h7F, 16'd0, 16'd0, 16'd7);
		poll_q.push_back(rand_poll(1'b1, 32'd12));
		poll_q.push_back(rand_poll(1'b0, 32'd13));

		configure(KIND_PAD, 16'hA5A5, 8'h00, 16'd0, 16'd0, 16'd0);
		pp = rand_poll(1'b1, 32'd20);
		pp.buttons = 16'h5A5A;
		poll_q.push_back(pp);
		poll_q.push_back(rand_poll(1'b0, 32'd21));

		configure(KIND_TRIG, 16'd0, 8'h00, 16'd0, 16'd0, 16'd0);
		pp = rand_poll(1'b1, 32'd30);
		pp.level = 8'd200;
		pp.lt = 8'd100;
		poll_q.push_back(pp);
		pp.level = 8'd50;
		poll_q.push_back(pp);
		configure(KIND_TRIG, 16'd1, 8'h00, 16'd0, 16'd0, 16'd0);
		pp.level = 8'hFF;
		pp.rt = 8'h00;
		poll_q.push_back(pp);
		configure(KIND_TRIG, 16'hFFFF, 8'h00, 16'd0, 16'd0, 16'd0);
		poll_q.push_back(pp);

		// random
		n_rand = 0;
		t = $urandom;
		while (n_rand < 525) begin
			if (n_rand >= 350) begin
				send_idle = 0;
				recv_idle = 0;
			end else if (n_rand >= 175) begin
				send_idle = 84;
				recv_idle = 33;
			end
			k = baar_kind_t'($urandom_range(7));
			case (k)
			KIND_MOUSE: code = 16'($urandom_range(0, 7));
			KIND_TRIG:  code = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 2));
			default:    code = 16'($urandom);
			endcase
			case ($urandom_range(4))
			0: steps = 8'h00;
			1: steps = 8'h80;
			2: steps = 8'h7F;
			default: steps = 8'($urandom);
			endcase
			kr = pick_interval();
			mr = pick_interval();
			wr = pick_interval();
			cur_rep = (k == KIND_KEY) ? kr : (k == KIND_MOUSE) ? mr :
				(wr != 16'd0) ? wr : WHEEL_DEFAULT_MS;
			configure(k, code, steps, kr, mr, wr);
			if ($urandom_range(5) == 0) t = 32'hFFFF_FFFF - 32'($urandom_range(300));
			pr = held_r;
			len = $urandom_range(30, 40);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(9))
				0: dt = 32'd0;
				1: dt = 32'd65535;
				2: dt = $urandom;
				3: dt = {16'd0, cur_rep};
				default: dt = 32'($urandom_range(1, 60));
				endcase
				t = t + dt;
				if ($urandom_range(5) == 0) pr = !pr;
				poll_q.push_back(rand_poll(pr, t));
			end
			n_rand += len;
		end

		settle();
		repeat (8) @(posedge clk);
		if (errs == 0 && event_beats_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/baar_pkg.sv
src/baar_front.sv
src/baar_fifo.sv
src/baar_back.sv
src/button_action_auto_repeat_core.sv
tb/sv/testbench.sv
